FILE: hdl/trs_world_matrix_macros.svh
// Assertion macros used by the checker file of the world matrix block.
`ifndef TRS_WORLD_MATRIX_MACROS_SVH
`define TRS_WORLD_MATRIX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("trs_world_matrix: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TWM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("trs_world_matrix: next-cycle check failed");

`endif

FILE: hdl/twm_pkg.sv
// Package: constants, tables, types and helpers of the world matrix block.
package twm_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int DATA_W       = 32;
	localparam int ANG_W        = 26;
	localparam int AMAG_W       = 25;
	localparam int CORDIC_STEPS = 30;
	localparam int CS_W         = 34;
	localparam int Z_W          = 33;
	localparam int PROD_W       = CS_W + DATA_W;

	localparam int IN_W  = 272;
	localparam int OUT_W = 384;
	localparam int ROT_LSB   = 3 * DATA_W;
	localparam int SCALE_LSB = ROT_LSB + 3 * ANG_W;

	// 360 degrees in the angle format
	localparam logic signed [ANG_W:0] PERIOD = (ANG_W+1)'(360 << FRAC_BITS);

	// phase = floor((a * 2^PH_SH + 180) / 360) = PH_Q*a + floor((PH_R*a + 180) / 360)
	localparam int PH_SH    = 32 - FRAC_BITS;
	localparam int PH_Q     = (1 << PH_SH) / 360;
	localparam int PH_R     = (1 << PH_SH) % 360;
	localparam int V_W      = 30;
	localparam int RECIP_W  = 32;
	localparam int RECIP_SH = 40;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'd359) / 64'd360);
	localparam int QUO_W = V_W + RECIP_W - RECIP_SH;

	localparam logic signed [CS_W-1:0] CORDIC_GAIN = CS_W'(32'h26DD3B6A);

	// arctangent of 2^-i in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	localparam logic signed [2*CS_W-1:0] RND30 = (2*CS_W)'(2**29);
	localparam logic signed [PROD_W-1:0] RND_OUT = PROD_W'(2**29);

	localparam logic signed [PROD_W-31:0] SAT_MAX = (PROD_W-30)'(32'sh7FFFFFFF);
	localparam logic signed [PROD_W-31:0] SAT_MIN = -(PROD_W-30)'(64'sh80000000);

	typedef struct packed {
		logic signed [DATA_W-1:0] scale_z;
		logic signed [DATA_W-1:0] scale_y;
		logic signed [DATA_W-1:0] scale_x;
		logic signed [DATA_W-1:0] pos_z;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] pos_x;
	} side_t;

	// product of two Q30 values, rounded half up back to Q30
	function automatic logic signed [CS_W-1:0] mul_q30(input logic signed [CS_W-1:0] a,
			input logic signed [CS_W-1:0] b);
		logic signed [2*CS_W-1:0] p;
		p = a * b;
		p = p + RND30;
		return p[30 +: CS_W];
	endfunction

endpackage

FILE: hdl/trs_world_matrix.sv
// Top level: pipelined affine world matrix T*Rx*Ry*Rz*S from position, Euler angles and scale.
//
// One beat in, one beat out: each input beat carries a position, three angles in degrees and a
// three-axis scale (position and scale signed Q16.16, angles signed Q10.16) and yields the top
// three rows of the world matrix. The block takes a beat every cycle while not stalled. Three
// stages reduce each angle to a 32-bit turn phase (modulo 360, then a multiply by the reciprocal
// of 360), thirty stages run one CORDIC rotation step each for the three angles side by side,
// two stages form the rotation products, one multiplies by the scale and the last rounds and
// saturates into the output register. The whole pipeline advances together whenever the output
// register is empty or being taken, so s_axis_tready falls only while a finished beat waits.
module trs_world_matrix (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// pos_x, pos_y, pos_z, rot_x_deg, rot_y_deg, rot_z_deg, scale_x, scale_y, scale_z, 2 pad bits
	input  logic [twm_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23
	output logic [twm_pkg::OUT_W-1:0] m_axis_tdata
);

	localparam int NS = twm_pkg::CORDIC_STEPS;
	localparam int CW = twm_pkg::CS_W;
	localparam int SIDE_STAGES = 36;

	logic adv;

	// side payload (position and scale) rides along the pipeline
	twm_pkg::side_t side_in;
	twm_pkg::side_t side_sp [1:SIDE_STAGES];

	// angle reduction and phase stages
	logic vld_s1, vld_s2, vld_s3;
	logic [twm_pkg::AMAG_W-1:0] ang_s1 [3];
	logic [twm_pkg::QUO_W-1:0]  quo_s2 [3];
	logic [31:0]                base_s2 [3];
	logic [31:0]                phase_s3 [3];

	// CORDIC stages 4 to 33
	logic                              vld_c [NS];
	logic signed [CW-1:0]              cx_c [NS][3];
	logic signed [CW-1:0]              cy_c [NS][3];
	logic signed [twm_pkg::Z_W-1:0]    cz_c [NS][3];
	logic [1:0]                        quad_c [NS][3];

	// product stages
	logic vld_s34, vld_s35, vld_s36, vld_s37;
	logic signed [CW-1:0] sxsy_s34, cxsy_s34, cycz_s34, cysz_s34, cxsz_s34, cxcz_s34;
	logic signed [CW-1:0] sxcy_s34, sxsz_s34, sxcz_s34, cxcy_s34, sy_s34, cz_s34, sz_s34;
	logic signed [CW-1:0] r_s35 [9];
	logic signed [twm_pkg::PROD_W-1:0] p_s36 [9];
	logic [twm_pkg::OUT_W-1:0] out_s37;

	// advance everything when the output register is free or being drained
	assign adv = !vld_s37 || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_s37;
	assign m_axis_tdata  = out_s37;

	assign side_in.pos_x   = s_axis_tdata[0 +: twm_pkg::DATA_W];
	assign side_in.pos_y   = s_axis_tdata[twm_pkg::DATA_W +: twm_pkg::DATA_W];
	assign side_in.pos_z   = s_axis_tdata[2*twm_pkg::DATA_W +: twm_pkg::DATA_W];
	assign side_in.scale_x = s_axis_tdata[twm_pkg::SCALE_LSB +: twm_pkg::DATA_W];
	assign side_in.scale_y = s_axis_tdata[twm_pkg::SCALE_LSB+twm_pkg::DATA_W +: twm_pkg::DATA_W];
	assign side_in.scale_z =
		s_axis_tdata[twm_pkg::SCALE_LSB+2*twm_pkg::DATA_W +: twm_pkg::DATA_W];

	// valid bits of the non-CORDIC stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s34 <= 1'b0;
			vld_s35 <= 1'b0;
			vld_s36 <= 1'b0;
			vld_s37 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= s_axis_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s34 <= vld_c[NS-1];
			vld_s35 <= vld_s34;
			vld_s36 <= vld_s35;
			vld_s37 <= vld_s36;
		end
	end

	// side payload delay line
	always_ff @(posedge clk) begin
		if (adv) begin
			side_sp[1] <= side_in;
			for (int i = 2; i <= SIDE_STAGES; i++) begin
				side_sp[i] <= side_sp[i-1];
			end
		end
	end

	// stage 1: fold each angle into [0, 360)
	always_ff @(posedge clk) begin
		logic signed [twm_pkg::ANG_W:0] raw;
		logic signed [twm_pkg::ANG_W:0] red;
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				raw = (twm_pkg::ANG_W+1)'($signed(
					s_axis_tdata[twm_pkg::ROT_LSB + k*twm_pkg::ANG_W +: twm_pkg::ANG_W]));
				if (raw >= twm_pkg::PERIOD) begin
					red = raw - twm_pkg::PERIOD;
				end else if (raw >= 0) begin
					red = raw;
				end else if (raw >= -twm_pkg::PERIOD) begin
					red = raw + twm_pkg::PERIOD;
				end else begin
					red = raw + (twm_pkg::PERIOD <<< 1);
				end
				ang_s1[k] <= red[twm_pkg::AMAG_W-1:0];
			end
		end
	end

	// stage 2: split the phase into a whole part and a divide by 360 via reciprocal
	always_ff @(posedge clk) begin
		logic [twm_pkg::V_W-1:0] v;
		logic [twm_pkg::V_W+twm_pkg::RECIP_W-1:0] prod;
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				v = twm_pkg::V_W'(twm_pkg::PH_R) * twm_pkg::V_W'(ang_s1[k]) + twm_pkg::V_W'(180);
				prod = (twm_pkg::V_W+twm_pkg::RECIP_W)'(v) *
					(twm_pkg::V_W+twm_pkg::RECIP_W)'(twm_pkg::RECIP);
				quo_s2[k]  <= prod[twm_pkg::V_W+twm_pkg::RECIP_W-1:twm_pkg::RECIP_SH];
				base_s2[k] <= 32'(twm_pkg::PH_Q) * 32'(ang_s1[k]);
			end
		end
	end

	// stage 3: turn phase, modulo 2^32
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				phase_s3[k] <= base_s2[k] + 32'(quo_s2[k]);
			end
		end
	end

	// stages 4 to 33: one CORDIC rotation step per stage
	for (genvar i = 0; i < NS; i++) begin : g_cordic
		logic                           vld_in;
		logic signed [CW-1:0]           x_in [3];
		logic signed [CW-1:0]           y_in [3];
		logic signed [twm_pkg::Z_W-1:0] z_in [3];
		logic [1:0]                     q_in [3];

		if (i == 0) begin : g_seed
			always_comb begin
				vld_in = vld_s3;
				for (int k = 0; k < 3; k++) begin
					x_in[k] = twm_pkg::CORDIC_GAIN;
					y_in[k] = '0;
					z_in[k] = {3'b000, phase_s3[k][29:0]};
					q_in[k] = phase_s3[k][31:30];
				end
			end
		end else begin : g_chain
			always_comb begin
				vld_in = vld_c[i-1];
				for (int k = 0; k < 3; k++) begin
					x_in[k] = cx_c[i-1][k];
					y_in[k] = cy_c[i-1][k];
					z_in[k] = cz_c[i-1][k];
					q_in[k] = quad_c[i-1][k];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[i] <= 1'b0;
			end else if (adv) begin
				vld_c[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int k = 0; k < 3; k++) begin
					quad_c[i][k] <= q_in[k];
					if (z_in[k] >= 0) begin
						cx_c[i][k] <= x_in[k] - (y_in[k] >>> i);
						cy_c[i][k] <= y_in[k] + (x_in[k] >>> i);
						cz_c[i][k] <= z_in[k] - twm_pkg::Z_W'(twm_pkg::ATAN_TURN[i]);
					end else begin
						cx_c[i][k] <= x_in[k] + (y_in[k] >>> i);
						cy_c[i][k] <= y_in[k] - (x_in[k] >>> i);
						cz_c[i][k] <= z_in[k] + twm_pkg::Z_W'(twm_pkg::ATAN_TURN[i]);
					end
				end
			end
		end
	end

	// stage 34: unfold quadrants, first-level products
	always_ff @(posedge clk) begin
		logic signed [CW-1:0] cs [3];
		logic signed [CW-1:0] sn [3];
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				case (quad_c[NS-1][k])
					2'd0: begin
						cs[k] = cx_c[NS-1][k];
						sn[k] = cy_c[NS-1][k];
					end
					2'd1: begin
						cs[k] = -cy_c[NS-1][k];
						sn[k] = cx_c[NS-1][k];
					end
					2'd2: begin
						cs[k] = -cx_c[NS-1][k];
						sn[k] = -cy_c[NS-1][k];
					end
					default: begin
						cs[k] = cy_c[NS-1][k];
						sn[k] = -cx_c[NS-1][k];
					end
				endcase
			end
			sxsy_s34 <= twm_pkg::mul_q30(sn[0], sn[1]);
			cxsy_s34 <= twm_pkg::mul_q30(cs[0], sn[1]);
			cycz_s34 <= twm_pkg::mul_q30(cs[1], cs[2]);
			cysz_s34 <= twm_pkg::mul_q30(cs[1], sn[2]);
			cxsz_s34 <= twm_pkg::mul_q30(cs[0], sn[2]);
			cxcz_s34 <= twm_pkg::mul_q30(cs[0], cs[2]);
			sxcy_s34 <= twm_pkg::mul_q30(sn[0], cs[1]);
			sxsz_s34 <= twm_pkg::mul_q30(sn[0], sn[2]);
			sxcz_s34 <= twm_pkg::mul_q30(sn[0], cs[2]);
			cxcy_s34 <= twm_pkg::mul_q30(cs[0], cs[1]);
			sy_s34   <= sn[1];
			cz_s34   <= cs[2];
			sz_s34   <= sn[2];
		end
	end

	// stage 35: rotation matrix Rx*Ry*Rz, row-major
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s35[0] <= cycz_s34;
			r_s35[1] <= -cysz_s34;
			r_s35[2] <= sy_s34;
			r_s35[3] <= twm_pkg::mul_q30(sxsy_s34, cz_s34) + cxsz_s34;
			r_s35[4] <= cxcz_s34 - twm_pkg::mul_q30(sxsy_s34, sz_s34);
			r_s35[5] <= -sxcy_s34;
			r_s35[6] <= sxsz_s34 - twm_pkg::mul_q30(cxsy_s34, cz_s34);
			r_s35[7] <= twm_pkg::mul_q30(cxsy_s34, sz_s34) + sxcz_s34;
			r_s35[8] <= cxcy_s34;
		end
	end

	// stage 36: multiply each column by its scale
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int rr = 0; rr < 3; rr++) begin
				p_s36[rr*3+0] <= r_s35[rr*3+0] * side_sp[35].scale_x;
				p_s36[rr*3+1] <= r_s35[rr*3+1] * side_sp[35].scale_y;
				p_s36[rr*3+2] <= r_s35[rr*3+2] * side_sp[35].scale_z;
			end
		end
	end

	// stage 37: round, saturate and pack with the position column
	always_ff @(posedge clk) begin
		logic signed [twm_pkg::PROD_W-1:0] t;
		logic signed [twm_pkg::PROD_W-31:0] rs;
		logic [twm_pkg::DATA_W-1:0] el;
		if (adv) begin
			for (int e = 0; e < 9; e++) begin
				t  = p_s36[e] + twm_pkg::RND_OUT;
				rs = t[twm_pkg::PROD_W-1:30];
				if (rs > twm_pkg::SAT_MAX) begin
					el = twm_pkg::SAT_MAX[twm_pkg::DATA_W-1:0];
				end else if (rs < twm_pkg::SAT_MIN) begin
					el = twm_pkg::SAT_MIN[twm_pkg::DATA_W-1:0];
				end else begin
					el = rs[twm_pkg::DATA_W-1:0];
				end
				out_s37[((e/3)*4 + (e%3))*twm_pkg::DATA_W +: twm_pkg::DATA_W] <= el;
			end
			out_s37[3*twm_pkg::DATA_W +: twm_pkg::DATA_W]  <= side_sp[SIDE_STAGES].pos_x;
			out_s37[7*twm_pkg::DATA_W +: twm_pkg::DATA_W]  <= side_sp[SIDE_STAGES].pos_y;
			out_s37[11*twm_pkg::DATA_W +: twm_pkg::DATA_W] <= side_sp[SIDE_STAGES].pos_z;
		end
	end

endmodule

FILE: hdl/twm_checker.sv
// Port-level checker for the world matrix block, bound to its top level.
`include "trs_world_matrix_macros.svh"

module twm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [twm_pkg::OUT_W-1:0] m_axis_tdata
);

	// a waiting result beat holds
	`TWM_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// input side stalls only while a result waits
	`TWM_ASSERT_IMP(a_rdy_rule, clk, arst_n, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

	// a stalled pipeline leaves the output untouched
	`TWM_ASSERT_NXT(a_stall_frz, clk, arst_n, !s_axis_tready, $stable(m_axis_tdata) && m_axis_tvalid)

endmodule

bind trs_world_matrix twm_checker u_twm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
